// File: hw/rtl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants for the sample frame queue.
// ----------------------------------------------------------------------------
package sfq_pkg;
	localparam int unsigned RING_DEPTH_DEF = 1024;
	localparam int unsigned FRAME_MAX_DEF  = 16;
	localparam int unsigned RESULT_CAP     = 64;
	localparam logic [9:0]  US_PER_MS      = 10'd1000;

	localparam logic [2:0] REG_FRAME_LENGTH = 3'd0;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
	localparam logic [2:0] REG_DROP_OLDEST  = 3'd2;
	localparam logic [2:0] REG_NEED_CONN    = 3'd3;
	localparam logic [2:0] REG_FLUSH_LIMIT  = 3'd4;

	typedef struct packed {
		logic [4:0]  frame_length;
		logic [19:0] smp_period;
		logic        drop_oldest;
		logic        need_connection;
		logic [2:0]  flush_limit;
	} cfg_t;

	localparam int unsigned IN_W  = 56;
	localparam int unsigned OUT_W = 72;
endpackage

// File: hw/rtl/sfq_time_unit.sv
// ----------------------------------------------------------------------------
// sfq_time_unit
// Pipelined time advance: base + (n * period) / 1000.
// ----------------------------------------------------------------------------
module sfq_time_unit import sfq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] base,
	input  logic [4:0]  n,
	input  logic [19:0] period,
	output logic        done,
	output logic [31:0] result
);
	// x / 1000 is (x >> 3) / 125; the scaled reciprocal of 125 is exact while
	// x stays below 2^24, which n * period does for n up to 16
	localparam logic [21:0] RECIP_125 = 22'd2147484;

	logic [23:0] num_s1;
	logic [31:0] base_s1;
	logic        vld_s1;
	logic [14:0] quo_s2;
	logic [42:0] prod;

	assign prod = {22'd0, num_s1[23:3]} * {21'd0, RECIP_125};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_s1  <= {19'd0, n} * {4'd0, period};
			base_s1 <= base;
		end
		if (vld_s1) begin
			quo_s2 <= prod[42:28];
		end
	end

	assign result = base_s1 + {17'd0, quo_s2};
endmodule

// File: hw/rtl/sfq_ring_mem.sv
// ----------------------------------------------------------------------------
// sfq_ring_mem
// Sample ring store, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfq_ring_mem import sfq_pkg::*; #(
	parameter int unsigned DEPTH = RING_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/sample_frame_queue_unit.sv
// ----------------------------------------------------------------------------
// sample_frame_queue_unit
// Frames timestamped samples, sends each frame at once or queues it in a ring, and flushes on ticks.
// ----------------------------------------------------------------------------
// channel | direction | content
// s_axis  | in        | one push or tick
// m_axis  | out       | one sent sample per transaction
// apb     | in        | register writes and reads
// A push that completes no frame passes through ST_PUSH_END and returns to idle.
// Queueing a frame takes one sample per ST_ENQ visit (lost if the ring is full
// without drop-oldest), with a time step in ST_ENQ_WAIT after each drop-oldest
// sample. A tick visits ST_TICK once per frame to check, then ST_DQ_RD and ST_DQ_WR
// for each dequeued sample, then a time step in ST_DQ_TIME unless the ring empties;
// sends run at one sample a cycle while m_axis is ready. Reset clears all control
// state; no clearing pass runs. Stalls on m_axis hold the sequencer.
module sample_frame_queue_unit import sfq_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	parameter int unsigned FRAME_MAX  = FRAME_MAX_DEF,
	localparam int unsigned AW = $clog2(RING_DEPTH),
	localparam int unsigned FW = $clog2(FRAME_MAX + 1) > 0 ? $clog2(FRAME_MAX + 1) : 1,
	localparam int unsigned BW = FRAME_MAX > 1 ? $clog2(FRAME_MAX) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] sample_value, [47:16] sample_time_ms, [48] link_connected,
	// [49] link_accepts, [55:50] zero
	input  logic [55:0] s_axis_tdata,
	// [0] func
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] out_sample, [47:16] frame_time_ms, [63:48] frame_seq,
	// [68:64] frame_count, [71:69] zero
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_PUSH_END, ST_ENQ, ST_ENQ_WAIT, ST_TICK, ST_DQ_RD, ST_DQ_WR,
		ST_DQ_TIME, ST_SEND_A, ST_SEND_P
	} state_t;

	state_t state_q;
	cfg_t   cfg_q;
	logic [15:0]   asm_buf_q [FRAME_MAX];
	logic [15:0]   pend_buf_q [FRAME_MAX];
	logic [FW-1:0] asm_len_q, pend_len_q, idx_q, n_q;
	logic [31:0]   asm_time_q, pend_time_q, queue_time_q;
	logic          qtv_q, pend_valid_q;
	logic [AW-1:0] head_q, tail_q;
	logic [AW:0]   count_q;
	logic [15:0]   seq_q;
	logic [2:0]    sent_q;
	logic [6:0]    k_q;
	logic          accepts_q, usable_q, pending_retry_q;

	logic [FW-1:0] eff_len;
	logic          usable;
	logic          ring_we;
	logic [15:0]   ring_rd;
	logic          tu_start, tu_done;
	logic [31:0]   tu_base, tu_res;
	logic [4:0]    tu_n;

	// wrap at the ring depth, which need not be a power of two
	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] ptr);
		return (ptr == AW'(RING_DEPTH - 1)) ? '0 : ptr + AW'(1);
	endfunction

	assign eff_len = (cfg_q.frame_length == 5'd0 || 32'(cfg_q.frame_length) > FRAME_MAX)
		? FW'(FRAME_MAX) : FW'(cfg_q.frame_length);
	assign usable = !cfg_q.need_connection || s_axis_tdata[48];
	assign pready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		unique case (paddr[4:2])
			REG_FRAME_LENGTH:  prdata = {27'd0, cfg_q.frame_length};
			REG_SAMPLE_PERIOD: prdata = {12'd0, cfg_q.smp_period};
			REG_DROP_OLDEST:   prdata = {31'd0, cfg_q.drop_oldest};
			REG_NEED_CONN:     prdata = {31'd0, cfg_q.need_connection};
			REG_FLUSH_LIMIT:   prdata = {29'd0, cfg_q.flush_limit};
			default:           prdata = '0;
		endcase
	end

	logic ring_full;
	assign ring_full = (count_q == (AW+1)'(RING_DEPTH));
	assign ring_we   = (state_q == ST_ENQ) && !(ring_full && !cfg_q.drop_oldest);

	sfq_ring_mem #(.DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(head_q), .wdata(asm_buf_q[idx_q[BW-1:0]]),
		.raddr(tail_q), .rdata(ring_rd)
	);

	sfq_time_unit u_time (
		.clk(clk), .arst_n(arst_n), .start(tu_start), .base(tu_base), .n(tu_n),
		.period(cfg_q.smp_period), .done(tu_done), .result(tu_res)
	);

	// drop-oldest advances by one sample, dequeue by n from the frame start
	assign tu_start = (state_q == ST_ENQ && ring_full && cfg_q.drop_oldest && qtv_q)
		|| (state_q == ST_DQ_WR && !(idx_q + FW'(1) < eff_len && count_q > (AW+1)'(1))
		&& count_q != (AW+1)'(1));
	assign tu_base = (state_q == ST_ENQ) ? queue_time_q : pend_time_q;
	assign tu_n    = (state_q == ST_ENQ) ? 5'd1 : 5'(idx_q + FW'(1));

	logic          send_a;
	logic [15:0]   o_sample;
	logic [31:0]   o_time;
	logic [FW-1:0] o_len;
	assign send_a   = (state_q == ST_SEND_A);
	assign o_sample = send_a ? asm_buf_q[idx_q[BW-1:0]] : pend_buf_q[idx_q[BW-1:0]];
	assign o_time   = send_a ? asm_time_q : pend_time_q;
	assign o_len    = send_a ? n_q : pend_len_q;
	assign m_axis_tvalid = (state_q == ST_SEND_A) || (state_q == ST_SEND_P);
	assign m_axis_tdata  = {3'd0, 5'(o_len), seq_q, o_time, o_sample};
	assign m_axis_tlast  = (idx_q + FW'(1) == o_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= '{frame_length: 5'd16, smp_period: 20'd1000,
				drop_oldest: 1'b0, need_connection: 1'b1, flush_limit: 3'd4};
			asm_len_q <= '0; pend_len_q <= '0; asm_time_q <= '0; pend_time_q <= '0;
			queue_time_q <= '0; qtv_q <= 1'b0; pend_valid_q <= 1'b0;
			head_q <= '0; tail_q <= '0; count_q <= '0; seq_q <= '0;
			idx_q <= '0; n_q <= '0; sent_q <= '0; k_q <= '0;
			accepts_q <= 1'b0; usable_q <= 1'b0; pending_retry_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[4:2])
					REG_FRAME_LENGTH:  cfg_q.frame_length <= pwdata[4:0];
					REG_SAMPLE_PERIOD: cfg_q.smp_period <= pwdata[19:0];
					REG_DROP_OLDEST:   cfg_q.drop_oldest <= pwdata[0];
					REG_NEED_CONN:     cfg_q.need_connection <= pwdata[0];
					REG_FLUSH_LIMIT:   cfg_q.flush_limit <= pwdata[2:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						accepts_q <= s_axis_tdata[49];
						usable_q  <= usable;
						if (!s_axis_tuser) begin
							if (asm_len_q == '0) asm_time_q <= s_axis_tdata[47:16];
							if (32'(asm_len_q) < FRAME_MAX) asm_len_q <= asm_len_q + FW'(1);
							state_q <= ST_PUSH_END;
						end else if (usable) begin
							k_q <= '0; sent_q <= '0; idx_q <= '0;
							if (pend_valid_q) begin
								if (s_axis_tdata[49]) begin
									pending_retry_q <= 1'b1;
									state_q <= ST_SEND_P;
								end
							end else begin
								state_q <= ST_TICK;
							end
						end
					end
				end
				ST_PUSH_END: begin
					if (asm_len_q < eff_len && 32'(asm_len_q) < FRAME_MAX) begin
						state_q <= ST_IDLE;
					end else begin
						n_q <= asm_len_q; asm_len_q <= '0; idx_q <= '0;
						if (count_q == '0 && !pend_valid_q && usable_q && accepts_q) begin
							state_q <= ST_SEND_A;
						end else begin
							if (count_q == '0 || !qtv_q) begin
								queue_time_q <= asm_time_q; qtv_q <= 1'b1;
							end
							state_q <= ST_ENQ;
						end
					end
				end
				ST_ENQ: begin
					if (ring_full) begin
						if (cfg_q.drop_oldest) begin
							tail_q <= ring_next(tail_q);
							head_q <= ring_next(head_q);
							if (qtv_q) state_q <= ST_ENQ_WAIT;
							else if (idx_q + FW'(1) == n_q) state_q <= ST_IDLE;
							idx_q <= idx_q + FW'(1);
						end else begin
							idx_q <= idx_q + FW'(1);
							if (idx_q + FW'(1) == n_q) state_q <= ST_IDLE;
						end
					end else begin
						head_q <= ring_next(head_q);
						count_q <= count_q + (AW+1)'(1);
						idx_q <= idx_q + FW'(1);
						if (idx_q + FW'(1) == n_q) state_q <= ST_IDLE;
					end
				end
				ST_ENQ_WAIT: begin
					if (tu_done) begin
						queue_time_q <= tu_res;
						state_q <= (idx_q == n_q) ? ST_IDLE : ST_ENQ;
					end
				end
				ST_TICK: begin
					if (count_q == '0 || (cfg_q.flush_limit != 3'd0 && sent_q >= cfg_q.flush_limit)
						|| (32'(k_q) + 32'(eff_len) > RESULT_CAP)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= '0; pend_time_q <= queue_time_q;
						state_q <= ST_DQ_RD;
					end
				end
				ST_DQ_RD: state_q <= ST_DQ_WR;
				ST_DQ_WR: begin
					tail_q  <= ring_next(tail_q);
					count_q <= count_q - (AW+1)'(1);
					if (idx_q + FW'(1) < eff_len && count_q > (AW+1)'(1)) begin
						idx_q <= idx_q + FW'(1);
						state_q <= ST_DQ_RD;
					end else begin
						pend_len_q <= idx_q + FW'(1);
						pend_valid_q <= 1'b1;
						idx_q <= '0;
						if (count_q == (AW+1)'(1)) begin
							qtv_q <= 1'b0;
							state_q <= accepts_q ? ST_SEND_P : ST_IDLE;
						end else begin
							state_q <= ST_DQ_TIME;
						end
					end
				end
				ST_DQ_TIME: begin
					if (tu_done) begin
						queue_time_q <= tu_res;
						state_q <= accepts_q ? ST_SEND_P : ST_IDLE;
					end
				end
				ST_SEND_A: begin
					if (m_axis_tready) begin
						idx_q <= idx_q + FW'(1);
						if (idx_q + FW'(1) == n_q) begin
							seq_q <= seq_q + 16'd1; state_q <= ST_IDLE;
						end
					end
				end
				ST_SEND_P: begin
					if (m_axis_tready) begin
						idx_q <= idx_q + FW'(1);
						k_q <= k_q + 7'd1;
						if (idx_q + FW'(1) == pend_len_q) begin
							seq_q <= seq_q + 16'd1;
							pend_valid_q <= 1'b0;
							idx_q <= '0;
							if (pending_retry_q) pending_retry_q <= 1'b0;
							else sent_q <= sent_q + 3'd1;
							state_q <= ST_TICK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && !s_axis_tuser
			&& 32'(asm_len_q) < FRAME_MAX) begin
			asm_buf_q[asm_len_q[BW-1:0]] <= s_axis_tdata[15:0];
		end
		if (state_q == ST_DQ_WR) begin
			pend_buf_q[idx_q[BW-1:0]] <= ring_rd;
		end
	end
endmodule

// File: hw/rtl/sfq_checker.sv
// ----------------------------------------------------------------------------
// sfq_checker
// Port-level checks for the sample frame queue.
// ----------------------------------------------------------------------------
module sfq_checker import sfq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output changed");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input ready while sending");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[68:64] != 5'd0) else $error("empty frame");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && $stable(m_axis_tdata[63:48])) else $error("seq moved mid-frame");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind sample_frame_queue_unit sfq_checker u_sfq_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .pready(pready)
);

// File: tb/sv/sfq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_scoreboard
// Watches the register port and both streams of the sample frame queue, keeps
// its own copy of the ring, assembly and pending state, predicts every sent
// sample and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module sfq_scoreboard import sfq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          outstanding,
	output int          items_seen,
	output int          samples_seen
);
	localparam int unsigned DEPTH = RING_DEPTH_DEF;
	localparam int unsigned FMAX  = FRAME_MAX_DEF;

	typedef struct {
		logic [15:0] smp;
		logic [31:0] t;
		logic [15:0] seqno;
		logic [4:0]  cnt;
		logic        last;
	} sent_sample_t;

	sent_sample_t sent_q[$];

	cfg_t        cfg;
	logic [15:0] ring[DEPTH];
	int unsigned rd_idx, wr_idx, ring_fill;
	logic [31:0] q_time;
	bit          q_time_ok;
	logic [15:0] asm_buf[FMAX];
	int unsigned asm_len;
	logic [31:0] asm_time;
	logic [15:0] pend_buf[FMAX];
	int unsigned pend_len;
	logic [31:0] pend_time;
	bit          pend_ok;
	logic [15:0] seq_ctr;
	int unsigned tick_samples;

	function automatic int unsigned eff_frame_len();
		if (cfg.frame_length == 0 || cfg.frame_length > FMAX) return FMAX;
		return cfg.frame_length;
	endfunction

	function automatic logic [31:0] step_time(logic [31:0] base, int unsigned n);
		logic [63:0] us;
		us = 64'(n) * 64'(cfg.smp_period);
		return base + 32'(us / 64'(US_PER_MS));
	endfunction

	task automatic ring_write(logic [15:0] v);
		if (ring_fill >= DEPTH) begin
			if (!cfg.drop_oldest) return;
			rd_idx = (rd_idx + 1) % DEPTH;
			ring_fill--;
			if (q_time_ok) q_time = step_time(q_time, 1);
		end
		ring[wr_idx] = v;
		wr_idx = (wr_idx + 1) % DEPTH;
		ring_fill++;
	endtask

	task automatic queue_frame(int unsigned n, logic [31:0] t);
		if (n == 0) return;
		if (ring_fill == 0 || !q_time_ok) begin
			q_time = t;
			q_time_ok = 1;
		end
		for (int unsigned i = 0; i < n && i < FMAX; i++) ring_write(asm_buf[i]);
	endtask

	function automatic int unsigned take_frame();
		int unsigned want, n;
		logic [31:0] t0;
		want = eff_frame_len();
		n = 0;
		t0 = q_time;
		while (n < want && ring_fill > 0) begin
			pend_buf[n] = ring[rd_idx];
			rd_idx = (rd_idx + 1) % DEPTH;
			ring_fill--;
			n++;
		end
		pend_len = n;
		pend_time = t0;
		if (ring_fill == 0) q_time_ok = 0;
		else q_time = step_time(t0, n);
		return n;
	endfunction

	task automatic send_frame(bit from_pend, int unsigned n, logic [31:0] t);
		sent_sample_t s;
		for (int unsigned i = 0; i < n && i < FMAX && tick_samples < RESULT_CAP; i++) begin
			s.smp   = from_pend ? pend_buf[i] : asm_buf[i];
			s.t     = t;
			s.seqno = seq_ctr;
			s.cnt   = 5'(n);
			s.last  = (i + 1 == n);
			sent_q.push_back(s);
			tick_samples++;
		end
		seq_ctr = seq_ctr + 16'd1;
	endtask

	task automatic predict_item(logic func, logic [15:0] v, logic [31:0] t,
			logic conn, logic acc);
		bit usable;
		int unsigned n, flushed;
		usable = !cfg.need_connection || conn;
		tick_samples = 0;
		flushed = 0;
		if (func == 1'b0) begin
			if (asm_len == 0) asm_time = t;
			if (asm_len < FMAX) begin
				asm_buf[asm_len] = v;
				asm_len++;
			end
			if (asm_len < eff_frame_len() && asm_len < FMAX) return;
			n = asm_len;
			asm_len = 0;
			if (ring_fill == 0 && !pend_ok && usable && acc) send_frame(0, n, asm_time);
			else queue_frame(n, asm_time);
			return;
		end
		if (!usable) return;
		if (pend_ok) begin
			if (!acc) return;
			send_frame(1, pend_len, pend_time);
			pend_ok = 0;
		end
		while (ring_fill > 0) begin
			if (cfg.flush_limit != 0 && flushed >= cfg.flush_limit) break;
			if (tick_samples + eff_frame_len() > RESULT_CAP) break;
			n = take_frame();
			if (n == 0) break;
			pend_ok = 1;
			if (!acc) return;
			send_frame(1, n, pend_time);
			pend_ok = 0;
			flushed++;
		end
	endtask

	task automatic compare_sample();
		sent_sample_t e;
		if (sent_q.size() == 0) begin
			$error("unexpected output transaction: data %h last %b", m_axis_tdata, m_axis_tlast);
			errors++;
			return;
		end
		e = sent_q.pop_front();
		if (m_axis_tdata[15:0] !== e.smp) begin
			$error("out_sample: expected %h, actual %h", e.smp, m_axis_tdata[15:0]);
			errors++;
		end
		if (m_axis_tdata[47:16] !== e.t) begin
			$error("frame_time_ms: expected %h, actual %h", e.t, m_axis_tdata[47:16]);
			errors++;
		end
		if (m_axis_tdata[63:48] !== e.seqno) begin
			$error("frame_seq: expected %h, actual %h", e.seqno, m_axis_tdata[63:48]);
			errors++;
		end
		if (m_axis_tdata[68:64] !== e.cnt) begin
			$error("frame_count: expected %0d, actual %0d", e.cnt, m_axis_tdata[68:64]);
			errors++;
		end
		if (m_axis_tlast !== e.last) begin
			$error("sample_last: expected %b, actual %b", e.last, m_axis_tlast);
			errors++;
		end
	endtask

	assign outstanding = sent_q.size();

	initial begin
		errors = 0;
		items_seen = 0;
		samples_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.frame_length = 5'd16;
			cfg.smp_period = 20'd1000;
			cfg.drop_oldest = 1'b0;
			cfg.need_connection = 1'b1;
			cfg.flush_limit = 3'd4;
			rd_idx = 0; wr_idx = 0; ring_fill = 0;
			q_time = '0; q_time_ok = 0;
			asm_len = 0; asm_time = '0;
			pend_len = 0; pend_time = '0; pend_ok = 0;
			seq_ctr = '0;
			sent_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				compare_sample();
				samples_seen++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FRAME_LENGTH:  cfg.frame_length = pwdata[4:0];
					REG_SAMPLE_PERIOD: cfg.smp_period = pwdata[19:0];
					REG_DROP_OLDEST:   cfg.drop_oldest = pwdata[0];
					REG_NEED_CONN:     cfg.need_connection = pwdata[0];
					REG_FLUSH_LIMIT:   cfg.flush_limit = pwdata[2:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
					s_axis_tdata[48], s_axis_tdata[49]);
				items_seen++;
			end
		end
	end
endmodule

// File: tb/sv/tb_sample_frame_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_frame_queue_unit
// Drives pushes and ticks into the sample frame queue under several register
// settings, a deep-queue pass that meets the per-tick cap and random stalls on
// both streams; the scoreboard checks every sent sample.
// ----------------------------------------------------------------------------
module tb_sample_frame_queue_unit;
	import sfq_pkg::*;

	localparam logic FN_PUSH = 1'b0;
	localparam logic FN_TICK = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// [15:0] sample_value, [47:16] sample_time_ms, [48] link_connected,
	// [49] link_accepts, [55:50] zero
	logic [55:0] s_axis_tdata;
	// [0] func
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [15:0] out_sample, [47:16] frame_time_ms, [63:48] frame_seq,
	// [68:64] frame_count, [71:69] zero
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	int errors, outstanding, items_seen, samples_seen;
	bit tx_idle;
	bit hold_req, hold_taken;

	sample_frame_queue_unit i_dut (.*);

	sfq_scoreboard i_scoreboard (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.errors, .outstanding, .items_seen, .samples_seen
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic offer(logic func, logic [15:0] v, logic [31:0] t, logic conn, logic acc);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {6'd0, acc, conn, t, v};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic push(logic conn, logic acc);
		offer(FN_PUSH, 16'($urandom), $urandom, conn, acc);
	endtask

	task automatic tick(logic conn, logic acc);
		offer(FN_TICK, 16'($urandom), $urandom, conn, acc);
	endtask

	// Drain every expected sample, then let a queueing pass finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic random_item();
		logic conn, acc;
		conn = ($urandom_range(0, 9) < 8);
		acc  = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 9) < 7) push(conn, acc);
		else tick(conn, acc);
	endtask

	task automatic deep_queue_pass();
		settle();
		reg_write(REG_FRAME_LENGTH, 32'd16);
		reg_write(REG_DROP_OLDEST, 32'($urandom_range(0, 1)));
		reg_write(REG_NEED_CONN, 32'd1);
		reg_write(REG_FLUSH_LIMIT, 32'd4);
		reg_write(REG_SAMPLE_PERIOD, 32'($urandom_range(1, 1000000)));
		repeat (80) push(1'b0, $urandom_range(0, 1));
		// Refused flush leaves a frame pending; the retry then meets the cap.
		tick(1'b1, 1'b0);
		hold_req <= 1'b1;
		tick(1'b1, 1'b1);
		tick(1'b1, 1'b1);
	endtask

	// Receiver: random stalls, stretches without them and one long hold.
	initial begin
		int w, n;
		m_axis_tready = 1'b0;
		hold_taken = 0;
		n = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				w = ((n / 40) % 3 != 0) ? $urandom_range(0, 5) : 0;
				if (w > 0) begin
					m_axis_tready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			n++;
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		tx_idle = 1;
		hold_req = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: direct send, link down, refused sends and retry.
		reg_write(REG_FRAME_LENGTH, 32'd2);
		offer(FN_PUSH, 16'h0000, 32'h0000_0000, 1'b1, 1'b1);
		offer(FN_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push(1'b0, 1'b1);
		push(1'b0, 1'b1);
		tick(1'b0, 1'b1);
		push(1'b1, 1'b0);
		push(1'b1, 1'b0);
		tick(1'b1, 1'b0);
		tick(1'b1, 1'b1);
		// Frame length lowered below the samples already gathered.
		settle();
		reg_write(REG_FRAME_LENGTH, 32'd4);
		repeat (3) push(1'b1, 1'b1);
		settle();
		reg_write(REG_FRAME_LENGTH, 32'd2);
		push(1'b1, 1'b1);
		// Largest period, timestamps wrapping, no connection needed, limit one.
		settle();
		reg_write(REG_SAMPLE_PERIOD, 32'd1000000);
		reg_write(REG_NEED_CONN, 32'd0);
		reg_write(REG_FLUSH_LIMIT, 32'd1);
		offer(FN_PUSH, 16'h1234, 32'hFFFF_FFF0, 1'b0, 1'b0);
		repeat (5) push(1'b0, 1'b0);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b1);

		// Random phases under varied settings.
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			reg_write(REG_FRAME_LENGTH,
				32'(($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 6)));
			reg_write(REG_SAMPLE_PERIOD,
				32'((ph == 0) ? 1 : (ph == 1) ? 1000000 : $urandom_range(1, 1000000)));
			reg_write(REG_DROP_OLDEST, 32'($urandom_range(0, 1)));
			reg_write(REG_NEED_CONN, 32'(ph % 2));
			reg_write(REG_FLUSH_LIMIT, 32'($urandom_range(1, 4)));
			tx_idle = (ph % 3 != 2);
			for (int i = 0; i < 8; i++) begin
				if (i == 4) settle();
				random_item();
			end
		end

		deep_queue_pass();

		settle();
		$display("Covered %0d items, %0d sent samples, a deep queue meeting the tick cap,",
			items_seen, samples_seen);
		$display("link loss, refused sends, pending retries and a long receiver hold.");
		if (errors == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// File: sample_frame_queue_unit.f
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_time_unit.sv
hw/rtl/sfq_ring_mem.sv
hw/rtl/sample_frame_queue_unit.sv
hw/rtl/sfq_checker.sv
tb/sv/sfq_scoreboard.sv
tb/sv/tb_sample_frame_queue_unit.sv
